[rtl/pqe_pkg.sv]
// ----------------------------------------------------------------------------
// pqe_pkg
// Types, codes and constant tables shared by the pick id quad expander.
// ----------------------------------------------------------------------------
`default_nettype none

package pqe_pkg;

  // shape kind codes on the input item
  localparam logic [2:0] KIND_QUAD    = 3'd0;
  localparam logic [2:0] KIND_CIRCLE  = 3'd1;
  localparam logic [2:0] KIND_CAPSULE = 3'd2;
  localparam logic [2:0] KIND_BOX     = 3'd3;
  localparam logic [2:0] KIND_MESH    = 3'd4;

  // record type codes on the result item
  localparam logic REC_VERTEX = 1'b0;
  localparam logic REC_INDEX  = 1'b1;

  // cordic setup
  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned CORDIC_W     = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // rounding constant for the q30 product sums
  localparam logic signed [65:0] ROUND_Q30 = 66'sd536870912;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_VERT,
    ST_IDX
  } state_e;

  typedef struct packed {
    logic               first_of_list;
    logic [2:0]         shape_kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        turn_angle;
    logic [30:0]        shape_radius;
    logic [30:0]        capsule_half_length;
    logic [30:0]        box_half_x;
    logic [30:0]        box_half_y;
  } in_item_t;

  typedef struct packed {
    logic               record_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic [30:0]        out_radius;
    logic [30:0]        out_half_length;
    logic [1:0]         kind_code;
    logic [16:0]        drawable_id;
    logic [17:0]        index_value;
    logic               last;
  } out_item_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [3:0] i);
    logic signed [CORDIC_W-1:0] a;
    unique case (i)
      4'd0:    a = 33'sh020000000;
      4'd1:    a = 33'sh012E4051D;
      4'd2:    a = 33'sh009FB385B;
      4'd3:    a = 33'sh0051111D4;
      4'd4:    a = 33'sh0028B0D43;
      4'd5:    a = 33'sh00145D7E1;
      4'd6:    a = 33'sh000A2F61E;
      4'd7:    a = 33'sh000517C55;
      4'd8:    a = 33'sh00028BE53;
      4'd9:    a = 33'sh000145F2E;
      4'd10:   a = 33'sh0000A2F98;
      4'd11:   a = 33'sh0000517CC;
      4'd12:   a = 33'sh000028BE6;
      4'd13:   a = 33'sh0000145F3;
      4'd14:   a = 33'sh00000A2F9;
      default: a = 33'sh00000517C;
    endcase
    return a;
  endfunction

  // vertex offsets of the two triangles of a quad
  function automatic logic [1:0] idx_offset(input logic [2:0] j);
    logic [1:0] o;
    unique case (j)
      3'd0:    o = 2'd0;
      3'd1:    o = 2'd1;
      3'd2:    o = 2'd2;
      3'd3:    o = 2'd0;
      3'd4:    o = 2'd2;
      default: o = 2'd3;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/pqe_if.sv]
// ----------------------------------------------------------------------------
// pqe_if
// Valid/ready channels carrying input shape items and result records.
// ----------------------------------------------------------------------------
`default_nettype none

interface pqe_in_if;
  logic               valid;
  logic               ready;
  pqe_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pqe_out_if;
  logic               valid;
  logic               ready;
  pqe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/pqe_cordic.sv]
// ----------------------------------------------------------------------------
// pqe_cordic
// Iterative cordic: cosine and sine in q30 of a 16-bit binary angle,
// one rotation step per cycle, quadrant folded in at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module pqe_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [15:0]        angle_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  localparam int unsigned W = pqe_pkg::CORDIC_W;

  logic signed [W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [W-1:0] dx, dy, ang;
  logic [3:0]          iter_q, iter_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [1:0]          quad_q, quad_d;

  // one rotation step
  always_comb begin
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    ang    = pqe_pkg::atan_angle(iter_q);
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    iter_d = iter_q;
    busy_d = busy_q;
    quad_d = quad_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = pqe_pkg::CORDIC_GAIN;
      y_d    = '0;
      z_d    = W'({angle_i[13:0], 16'h0000});
      quad_d = angle_i[15:14];
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end
      iter_d = iter_q + 4'd1;
      if (iter_q == 4'(pqe_pkg::CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  // quadrant fold
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = 32'(x_q);
        sin_o = 32'(y_q);
      end
      2'd1: begin
        cos_o = 32'(-y_q);
        sin_o = 32'(x_q);
      end
      2'd2: begin
        cos_o = 32'(-x_q);
        sin_o = 32'(-y_q);
      end
      default: begin
        cos_o = 32'(y_q);
        sin_o = 32'(-x_q);
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[rtl/pick_id_quad_expander_unit.sv]
// ----------------------------------------------------------------------------
// pick_id_quad_expander_unit
// Expands pickable shapes into id-tagged vertex and index records.
// ----------------------------------------------------------------------------
// One shape item is taken at a time. A quad corner gives one vertex record
// when the output register is free, and the fourth corner adds 6 index
// records, one per cycle while the output is not stalled. A circle, capsule
// or box runs the 16-step shared cordic, then four products on the single
// 32x32 multiplier, then 4 vertex and 6 index records at one per cycle
// while the output is not stalled. A mesh or an unknown kind gives no record.
`default_nettype none

module pick_id_quad_expander_unit #(
  parameter int unsigned MAX_SHAPES = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pqe_in_if.sink     in_i,
  pqe_out_if.source  out_o
);

  localparam int unsigned VERT_LIMIT = 4 * MAX_SHAPES;
  localparam int unsigned ID_W       = $clog2(MAX_SHAPES + 1);
  localparam int unsigned VC_W       = $clog2(VERT_LIMIT + 1);
  localparam logic [ID_W-1:0] ID_MAX = ID_W'(MAX_SHAPES);
  localparam logic [VC_W-1:0] VC_MAX = VC_W'(VERT_LIMIT);
  localparam logic [VC_W:0]   VN_MAX = (VC_W + 1)'(VERT_LIMIT - 1);

  pqe_pkg::state_e    state_q, state_d;
  logic [ID_W-1:0]    shapes_q, shapes_d, id_q, id_d;
  logic [VC_W-1:0]    vert_q, vert_d, base_q, base_d;
  logic [1:0]         qcnt_q, qcnt_d, kind_q, kind_d;
  logic [2:0]         step_q, step_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [30:0]        bx_q, bx_d, by_q, by_d, rad_q, rad_d, hl_q, hl_d;
  logic signed [31:0] cs_q, cs_d, sn_q, sn_d;
  logic signed [63:0] prod_q [4];
  pqe_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               out_load, in_fire, cordic_start, cordic_done, prod_we;
  logic signed [31:0] cordic_cos, cordic_sin;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  // ---------------------------------------------------------------------
  // helpers
  function automatic logic [ID_W-1:0] id_inc(input logic [ID_W-1:0] v);
    return (v < ID_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [VC_W-1:0] vert_num(input logic [VC_W-1:0] v);
    return (v < VC_MAX - 1'b1) ? v : VC_MAX - 1'b1;
  endfunction

  function automatic logic [VC_W-1:0] vert_inc(input logic [VC_W-1:0] v);
    return (v < VC_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // shared cordic
  pqe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (in_i.data.turn_angle),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  // shared multiplier: c*bx, s*by, s*bx, c*by
  always_comb begin
    mul_a = (step_q == 3'd0 || step_q == 3'd3) ? cs_q : sn_q;
    mul_b = (step_q == 3'd0 || step_q == 3'd2) ? $signed({1'b0, bx_q})
                                               : $signed({1'b0, by_q});
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (prod_we) prod_q[step_q[1:0]] <= mul_p;
  end

  assign out_load   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == pqe_pkg::ST_IDLE) && out_load;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------
  // sequencer and record assembly
  always_comb begin
    logic [ID_W-1:0]    ss_c, id_n;
    logic [VC_W-1:0]    ve_c, vnum;
    logic [1:0]         qc_c;
    logic [31:0]        cap_sum;
    logic               sx, sy;
    logic signed [65:0] p0, p1, p2, p3, tx, ty;
    logic signed [35:0] rx, ry;
    logic [VC_W:0]      isum;

    state_d      = state_q;
    shapes_d     = shapes_q;
    id_d         = id_q;
    vert_d       = vert_q;
    base_d       = base_q;
    qcnt_d       = qcnt_q;
    kind_d       = kind_q;
    step_d       = step_q;
    px_d         = px_q;
    py_d         = py_q;
    pz_d         = pz_q;
    bx_d         = bx_q;
    by_d         = by_q;
    rad_d        = rad_q;
    hl_d         = hl_q;
    cs_d         = cs_q;
    sn_d         = sn_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    cordic_start = 1'b0;
    prod_we      = 1'b0;

    ss_c    = in_i.data.first_of_list ? '0 : shapes_q;
    ve_c    = in_i.data.first_of_list ? '0 : vert_q;
    qc_c    = in_i.data.first_of_list ? '0 : qcnt_q;
    id_n    = '0;
    vnum    = vert_num(vert_q);
    cap_sum = {1'b0, in_i.data.capsule_half_length} + {1'b0, in_i.data.shape_radius};

    sx = (step_q == 3'd1) || (step_q == 3'd2);
    sy = step_q[1];
    p0 = 66'(prod_q[0]);
    p1 = 66'(prod_q[1]);
    p2 = 66'(prod_q[2]);
    p3 = 66'(prod_q[3]);
    tx = (sx ? p0 : -p0) - (sy ? p1 : -p1) + pqe_pkg::ROUND_Q30;
    ty = (sx ? p2 : -p2) + (sy ? p3 : -p3) + pqe_pkg::ROUND_Q30;
    rx = 36'(tx >>> 30);
    ry = 36'(ty >>> 30);
    isum = {1'b0, base_q} + (VC_W + 1)'(pqe_pkg::idx_offset(step_q));

    unique case (state_q)
      pqe_pkg::ST_IDLE: begin
        if (in_fire) begin
          shapes_d = ss_c;
          vert_d   = ve_c;
          qcnt_d   = qc_c;
          case (in_i.data.shape_kind)
            pqe_pkg::KIND_QUAD: begin
              id_n     = (qc_c == 2'd0) ? id_inc(ss_c) : ss_c;
              shapes_d = id_n;
              id_d     = id_n;
              kind_d   = 2'd0;
              vert_d   = vert_inc(ve_c);
              if (qc_c == 2'd0) base_d = vert_num(ve_c);
              out_d                 = '0;
              out_d.record_type     = pqe_pkg::REC_VERTEX;
              out_d.pos_x           = in_i.data.point_x;
              out_d.pos_y           = in_i.data.point_y;
              out_d.pos_z           = in_i.data.point_z;
              out_d.drawable_id     = 17'(id_n);
              out_d.last            = (qc_c != 2'd3);
              out_valid_d           = 1'b1;
              if (qc_c == 2'd3) begin
                qcnt_d  = 2'd0;
                step_d  = '0;
                state_d = pqe_pkg::ST_IDX;
              end else begin
                qcnt_d = qc_c + 2'd1;
              end
            end
            pqe_pkg::KIND_MESH: begin
              qcnt_d   = 2'd0;
              shapes_d = id_inc(ss_c);
            end
            pqe_pkg::KIND_CIRCLE, pqe_pkg::KIND_CAPSULE, pqe_pkg::KIND_BOX: begin
              qcnt_d   = 2'd0;
              id_n     = id_inc(ss_c);
              shapes_d = id_n;
              id_d     = id_n;
              kind_d   = in_i.data.shape_kind[1:0];
              px_d     = in_i.data.point_x;
              py_d     = in_i.data.point_y;
              pz_d     = in_i.data.point_z;
              rad_d    = (in_i.data.shape_kind == pqe_pkg::KIND_BOX)
                         ? '0 : in_i.data.shape_radius;
              hl_d     = (in_i.data.shape_kind == pqe_pkg::KIND_CAPSULE)
                         ? in_i.data.capsule_half_length : '0;
              if (in_i.data.shape_kind == pqe_pkg::KIND_BOX) begin
                bx_d = in_i.data.box_half_x;
                by_d = in_i.data.box_half_y;
              end else if (in_i.data.shape_kind == pqe_pkg::KIND_CAPSULE) begin
                bx_d = cap_sum[31] ? 31'h7FFFFFFF : cap_sum[30:0];
                by_d = in_i.data.shape_radius;
              end else begin
                bx_d = in_i.data.shape_radius;
                by_d = in_i.data.shape_radius;
              end
              cordic_start = 1'b1;
              state_d      = pqe_pkg::ST_CORDIC;
            end
            default: ;
          endcase
        end
      end
      pqe_pkg::ST_CORDIC: begin
        if (cordic_done) begin
          cs_d    = cordic_cos;
          sn_d    = cordic_sin;
          step_d  = '0;
          state_d = pqe_pkg::ST_MUL;
        end
      end
      pqe_pkg::ST_MUL: begin
        prod_we = 1'b1;
        if (step_q == 3'd3) begin
          step_d  = '0;
          state_d = pqe_pkg::ST_VERT;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      pqe_pkg::ST_VERT: begin
        if (out_load) begin
          vert_d = vert_inc(vert_q);
          if (step_q == 3'd0) base_d = vnum;
          out_d                 = '0;
          out_d.record_type     = pqe_pkg::REC_VERTEX;
          out_d.pos_x           = sat32(36'(px_q) + rx);
          out_d.pos_y           = sat32(36'(py_q) + ry);
          out_d.pos_z           = pz_q;
          out_d.local_x         = sx ? $signed({1'b0, bx_q}) : -$signed({1'b0, bx_q});
          out_d.local_y         = sy ? $signed({1'b0, by_q}) : -$signed({1'b0, by_q});
          out_d.out_radius      = rad_q;
          out_d.out_half_length = hl_q;
          out_d.kind_code       = kind_q;
          out_d.drawable_id     = 17'(id_q);
          out_d.last            = 1'b0;
          out_valid_d           = 1'b1;
          if (step_q == 3'd3) begin
            step_d  = '0;
            state_d = pqe_pkg::ST_IDX;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      pqe_pkg::ST_IDX: begin
        if (out_load) begin
          out_d             = '0;
          out_d.record_type = pqe_pkg::REC_INDEX;
          out_d.kind_code   = kind_q;
          out_d.drawable_id = 17'(id_q);
          out_d.index_value = 18'((isum > VN_MAX) ? VN_MAX : isum);
          out_d.last        = (step_q == 3'd5);
          out_valid_d       = 1'b1;
          if (step_q == 3'd5) begin
            step_d  = '0;
            state_d = pqe_pkg::ST_IDLE;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      default: state_d = pqe_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqe_pkg::ST_IDLE;
      shapes_q    <= '0;
      vert_q      <= '0;
      qcnt_q      <= '0;
      base_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shapes_q    <= shapes_d;
      vert_q      <= vert_d;
      qcnt_q      <= qcnt_d;
      base_q      <= base_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    kind_q <= kind_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    rad_q  <= rad_d;
    hl_q   <= hl_d;
    cs_q   <= cs_d;
    sn_q   <= sn_d;
    out_q  <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  a_vert_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_q <= VC_MAX)
    else $error("vertex count beyond limit");

  a_id_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shapes_q <= ID_MAX)
    else $error("shape count beyond limit");

  a_id_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pqe_pkg::ST_VERT || state_q == pqe_pkg::ST_IDX) |-> id_q != '0)
    else $error("records emitted without an id");

  a_cordic_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == pqe_pkg::ST_CORDIC)
    else $error("cordic finished outside its wait state");

endmodule

`default_nettype wire
